[rtl/ppd_pkg.sv]
// Package for the prefix period detector: sizes, payload structs and state enums.
`default_nettype none

package ppd_pkg;

    // Longest string that is tracked; later bytes are dropped
    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = 13;
    localparam int CNT_W   = $clog2(LEN_W);

    // Job queue between walker and divider
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] prefix_length;
        logic [OUT_W-1:0] repeat_count;
    } t_out;

    // Prefix length and its nonzero border, handed to the divider
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] border;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_CMP,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_bstate;

endpackage

`default_nettype wire

[rtl/ppd_fifo.sv]
// Short register queue carrying border jobs from the walker to the divider.
`default_nettype none

module ppd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ppd_pkg::t_job i_push_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output ppd_pkg::t_job      o_pop_data,
    output logic               o_empty
);

    ppd_pkg::t_job                    r_mem [ppd_pkg::FIFO_DEPTH];
    logic [ppd_pkg::FIFO_PTR_W-1:0]   r_wptr;
    logic [ppd_pkg::FIFO_PTR_W-1:0]   r_rptr;
    logic [ppd_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full     = (r_count == ppd_pkg::FIFO_CNT_W'(ppd_pkg::FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppd_pkg::FIFO_CNT_W'(ppd_pkg::FIFO_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push while queue full");

    a_wrap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr != r_rptr) |-> (r_count != '0) && !o_full)
        else $error("pointers disagree with count");

endmodule

`default_nettype wire

[rtl/ppd_kmp.sv]
// Front end: accepts bytes, stores them and walks the border table to find each border.
`default_nettype none

module ppd_kmp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire ppd_pkg::t_in  i_data,
    output logic               o_stall,
    output logic               o_push,
    output ppd_pkg::t_job      o_push_data,
    input  wire logic          i_full
);

    localparam int AW = ppd_pkg::ADDR_W;
    localparam int LW = ppd_pkg::LEN_W;

    ppd_pkg::t_fstate  r_state, n_state;
    logic [LW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_cb, n_cb;
    logic [AW-1:0]     r_b, n_b;
    logic [7:0]        r_ch, n_ch;
    ppd_pkg::t_job     r_job, n_job;

    logic [7:0]        text_store   [ppd_pkg::MAX_LEN];
    logic [AW-1:0]     border_table [ppd_pkg::MAX_LEN];
    logic [7:0]        r_tdat;
    logic [AW-1:0]     r_bdat;

    logic              accept;
    logic [LW-1:0]     pos_eff;
    logic [AW-1:0]     cb_eff;
    logic              ts_we;
    logic [AW-1:0]     ts_wa;
    logic              bt_we;
    logic [AW-1:0]     bt_wa;
    logic [AW-1:0]     bt_wdata;
    logic              match;
    logic [AW-1:0]     b_new;

    assign o_stall     = (r_state != ppd_pkg::F_IDLE);
    assign accept      = i_valid && !o_stall;
    assign o_push_data = r_job;

    // a new string restarts position and border
    assign pos_eff = i_data.first ? '0 : r_pos;
    assign cb_eff  = i_data.first ? '0 : r_cb;
    assign match   = (r_tdat == r_ch);
    assign b_new   = r_b + AW'(match);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppd_pkg::F_IDLE;
            r_pos   <= '0;
            r_cb    <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cb    <= n_cb;
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_ch  <= n_ch;
        r_job <= n_job;
    end

    // byte store: written on accept, read during the walk
    always_ff @(posedge i_clk) begin
        if (ts_we) begin
            text_store[ts_wa] <= i_data.ch;
        end
        if (r_state == ppd_pkg::F_READ) begin
            r_tdat <= text_store[r_b];
        end
    end

    // border table: link of border b sits at entry b-1
    always_ff @(posedge i_clk) begin
        if (bt_we) begin
            border_table[bt_wa] <= bt_wdata;
        end
        if (r_state == ppd_pkg::F_READ) begin
            r_bdat <= border_table[r_b - AW'(1)];
        end
    end

    // next state and control
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_cb     = r_cb;
        n_b      = r_b;
        n_ch     = r_ch;
        n_job    = r_job;
        ts_we    = 1'b0;
        ts_wa    = pos_eff[AW-1:0];
        bt_we    = 1'b0;
        bt_wa    = r_pos[AW-1:0];
        bt_wdata = '0;
        o_push   = 1'b0;
        case (r_state)
            ppd_pkg::F_IDLE: begin
                if (accept) begin
                    n_pos = pos_eff;
                    n_cb  = cb_eff;
                    if (pos_eff < LW'(ppd_pkg::MAX_LEN)) begin
                        ts_we = 1'b1;
                        n_ch  = i_data.ch;
                        if (pos_eff == '0) begin
                            // first byte: border zero, never periodic
                            bt_we    = 1'b1;
                            bt_wa    = '0;
                            bt_wdata = '0;
                            n_cb     = '0;
                            n_pos    = LW'(1);
                        end else begin
                            n_b     = cb_eff;
                            n_state = ppd_pkg::F_READ;
                        end
                    end
                end
            end
            ppd_pkg::F_READ: begin
                n_state = ppd_pkg::F_CMP;
            end
            ppd_pkg::F_CMP: begin
                if ((r_b != '0) && !match) begin
                    // follow the fallback link
                    n_b     = (r_bdat < r_b) ? r_bdat : '0;
                    n_state = ppd_pkg::F_READ;
                end else begin
                    bt_we      = 1'b1;
                    bt_wdata   = b_new;
                    n_cb       = b_new;
                    n_pos      = r_pos + LW'(1);
                    n_job.len    = r_pos + LW'(1);
                    n_job.border = b_new;
                    n_state    = (b_new != '0) ? ppd_pkg::F_PUSH : ppd_pkg::F_IDLE;
                end
            end
            ppd_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = ppd_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = ppd_pkg::F_IDLE;
            end
        endcase
    end

    a_border_below_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppd_pkg::F_READ || r_state == ppd_pkg::F_CMP)
        |-> (LW'(r_b) < r_pos))
        else $error("walk border not below position");

    a_job_border_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_job.border != '0) && (LW'(r_job.border) < r_job.len))
        else $error("bad job pushed");

    a_cb_below_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (LW'(r_cb) < r_pos))
        else $error("current border not below position");

endmodule

`default_nettype wire

[rtl/ppd_div.sv]
// Back end: divides prefix length by its period and emits periodic prefixes.
`default_nettype none

module ppd_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire ppd_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    output ppd_pkg::t_out      o_data,
    input  wire logic          i_stall
);

    localparam int LW = ppd_pkg::LEN_W;
    localparam int CW = ppd_pkg::CNT_W;

    ppd_pkg::t_bstate  r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [LW-1:0]     r_num;
    logic [LW-1:0]     r_div;
    logic [LW-1:0]     r_quo;
    logic [LW-1:0]     r_rem;
    logic              r_ovalid;
    ppd_pkg::t_out     r_odata;

    logic [LW:0]       trial;
    logic              fits;
    logic              load_out;

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[LW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ppd_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ppd_pkg::B_DIV;
                end
            end
            ppd_pkg::B_DIV: begin
                if (r_cnt == CW'(LW - 1)) begin
                    n_state = ppd_pkg::B_DONE;
                end
            end
            ppd_pkg::B_DONE: begin
                if (r_rem != '0) begin
                    n_state = ppd_pkg::B_IDLE;
                end else if (!r_ovalid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = ppd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = ppd_pkg::B_IDLE;
            end
        endcase
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_num <= i_job.len;
            r_div <= i_job.len - LW'(i_job.border);
            r_quo <= i_job.len;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == ppd_pkg::B_DIV) begin
            r_cnt <= r_cnt + CW'(1);
            r_quo <= {r_quo[LW-2:0], fits};
            r_rem <= fits ? LW'(trial - {1'b0, r_div}) : trial[LW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata.prefix_length <= ppd_pkg::OUT_W'(r_num);
            r_odata.repeat_count  <= ppd_pkg::OUT_W'(r_quo);
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppd_pkg::B_DONE) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppd_pkg::B_DIV) |-> (r_div != '0) && (r_div < r_num))
        else $error("period out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_rem == '0) && (r_quo >= LW'(2)))
        else $error("bad result loaded");

endmodule

`default_nettype wire

[rtl/prefix_period_detector.sv]
// Top level of the prefix period detector: border walker, job queue and divider.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_stall      ppd_pkg::t_in  {ch, first}
//   out      output     o_out_valid / i_out_stall    ppd_pkg::t_out {prefix_length, repeat_count}
//
// A byte that opens a string or lies past the length limit is taken without a stall;
// any other byte goes through accept, read and compare in the walker, plus a read and
// compare per fallback link, then a push when its border is nonzero, held while full.
// Behind a 4-entry queue the divider pops each job, runs 13 restoring steps and checks
// the remainder; the output register holds one result while the next one is worked out.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module prefix_period_detector (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire ppd_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ppd_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);

    logic            push;
    ppd_pkg::t_job   push_data;
    logic            full;
    logic            pop;
    ppd_pkg::t_job   pop_data;
    logic            empty;

    ppd_kmp u_kmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .o_stall     (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    ppd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    ppd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_data),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

[tb/sv/tb_prefix_period_detector.sv]
// Self-checking testbench for the prefix period detector with a built-in border predictor.
`timescale 1ns / 100ps

module tb_prefix_period_detector;

    // Cycles without any transaction before the run is declared hung
    localparam int STUCK_LIMIT = 20000;
    // Walker, job queue and divider drain time after the last result
    localparam int TAIL_CYCLES = 100;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    ppd_pkg::t_in  i_in_data   = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    ppd_pkg::t_out o_out_data;

    // Predictor state: bytes and borders of the current string
    logic [7:0]                 byte_store   [0:ppd_pkg::MAX_LEN-1];
    logic [ppd_pkg::ADDR_W-1:0] border_store [0:ppd_pkg::MAX_LEN-1];
    int                str_len     = 0;
    int                border_now  = 0;

    ppd_pkg::t_out pending_periods [$];
    int   fault_count  = 0;
    int   stuck_cycles = 0;
    bit   calm_tail    = 1'b0;

    prefix_period_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Online border update; reports a result when the prefix is an exact repeat
    function automatic void advance_string(input ppd_pkg::t_in item, output bit hit,
                                           output ppd_pkg::t_out res);
        int b;
        int len;
        int span;
        hit = 1'b0;
        res = '0;
        if (item.first) begin
            str_len    = 0;
            border_now = 0;
        end
        if (str_len >= ppd_pkg::MAX_LEN)
            return;
        byte_store[str_len] = item.ch;
        if (str_len == 0) begin
            border_store[0] = '0;
            border_now      = 0;
            str_len         = 1;
            return;
        end
        // follow fallback links until the next byte extends a border
        b = border_now;
        while (b > 0 && byte_store[b] != item.ch)
            b = (int'(border_store[b-1]) < b) ? int'(border_store[b-1]) : 0;
        if (byte_store[b] == item.ch)
            b++;
        border_store[str_len] = ppd_pkg::ADDR_W'(b);
        border_now = b;
        len        = str_len + 1;
        str_len    = len;
        if (b == 0)
            return;
        span = len - b;
        if (len % span != 0)
            return;
        hit = 1'b1;
        res.prefix_length = ppd_pkg::OUT_W'(len);
        res.repeat_count  = ppd_pkg::OUT_W'(len / span);
    endfunction

    // Receiver: random stall bursts, none during the tail
    initial begin : out_stall_gen
        bit stall_now;
        int n;
        forever begin
            stall_now = ($urandom_range(0, 2) == 0);
            n = stall_now ? $urandom_range(1, 16) : $urandom_range(1, 40);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= stall_now && !calm_tail;
            end
        end
    end

    // Result checker: every output transaction against the oldest prediction
    always @(posedge i_clk) begin : check_results
        ppd_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_periods.size() == 0) begin
                $display("%0t: result with none predicted: expected nothing, actual len %0d rep %0d",
                         $time, o_out_data.prefix_length, o_out_data.repeat_count);
                fault_count++;
            end else begin
                want = pending_periods.pop_front();
                if (o_out_data.prefix_length !== want.prefix_length) begin
                    $display("%0t: prefix_length mismatch: expected %0d actual %0d",
                             $time, want.prefix_length, o_out_data.prefix_length);
                    fault_count++;
                end
                if (o_out_data.repeat_count !== want.repeat_count) begin
                    $display("%0t: repeat_count mismatch: expected %0d actual %0d",
                             $time, want.repeat_count, o_out_data.repeat_count);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("prefix_period_detector regression: fail");
        $finish;
    end

    // Send one byte, wait for its transaction, record the predicted result
    task automatic send_char(input logic [7:0] c, input logic f);
        ppd_pkg::t_in  item;
        bit            hit;
        ppd_pkg::t_out res;
        item.ch    = c;
        item.first = f;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        advance_string(item, hit, res);
        if (hit)
            pending_periods.push_back(res);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_periods.size() != 0) @(posedge i_clk);
    endtask

    // Bytes right after reset with no first flag form one string
    task automatic test_start_without_first();
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
    endtask

    // Single byte, zero bytes, byte extremes, fallback walk and restart
    task automatic test_directed_cases();
        send_char(8'h7E, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'h80, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h55, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hAA, 1'b1);
        send_char(8'hAA, 1'b0);
    endtask

    // Long run of one byte, every prefix repeats with period one, then a restart
    task automatic test_long_run();
        send_char(8'hA5, 1'b1);
        repeat (255) send_char(8'hA5, 1'b0);
        send_char(8'h33, 1'b1);
        send_char(8'h33, 1'b0);
    endtask

    // Mostly periodic strings over small alphabets, some broken, some noise
    task automatic test_random_strings(input int target);
        logic [7:0] unit [0:63];
        logic [7:0] base;
        logic [7:0] c;
        int sent;
        int kind;
        int span;
        int alph;
        int len;
        int flip_at;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            alph = $urandom_range(1, 4);
            base = 8'($urandom_range(0, 255));
            for (int i = 0; i < span; i++)
                unit[i] = base + 8'($urandom_range(0, alph - 1));
            len = $urandom_range(span, 64);
            flip_at = (kind == 6) ? $urandom_range(1, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                // kinds 7 and 8 are noise, 6 has one corrupted byte, 9 continues a string
                if (kind == 7 || kind == 8 || i == flip_at)
                    c = 8'($urandom_range(0, 255));
                else
                    c = unit[i % span];
                send_char(c, (i == 0) && (kind != 9));
            end
            sent += len;
        end
    endtask

    initial begin : main
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_without_first();
        test_directed_cases();
        test_long_run();
        test_random_strings(170);
        wait_results_drained();
        test_random_strings(170);
        calm_tail = 1'b1;
        test_random_strings(60);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_periods.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_periods.size() == 0)
            $display("prefix_period_detector regression: pass");
        else
            $display("prefix_period_detector regression: fail");
        $finish;
    end

endmodule
